/* rtl/pad_pkg.sv */
// shared types, constants and arctangent table for the point azimuth block
`default_nettype none

package pad_pkg;

   // default coordinate width and cordic stage count
   localparam int COORD_BITS_DEF    = 12;
   localparam int CORDIC_STAGES_DEF = 24;

   // fixed-point scaling of the cordic vector and width of the angle accumulator
   localparam int CORDIC_SCALE = 30;
   localparam int Z_BITS       = 34;

   // center position after reset
   localparam int CENTER_RESET = 300;

   // binary angle landmarks, a full turn is 2^32
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

   // arc-second conversion constants
   localparam int unsigned ARCSEC_PER_TURN = 1296000;
   localparam int unsigned SEC_PER_DEG     = 3600;
   localparam int unsigned SEC_PER_MIN     = 60;

   // floor reciprocals for constant division, estimate is low by at most one
   localparam int DEG_RECIP_SHIFT = 32;
   localparam longint unsigned DEG_RECIP = 64'd4294967296 / 64'd3600;
   localparam int MIN_RECIP_SHIFT = 18;
   localparam int unsigned MIN_RECIP = (1 << 18) / 60;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_CENTER_X = 1'b0,
      CSR_CENTER_Y = 1'b1
   } csr_index_type;

   // per-point side information that travels with the cordic vector
   typedef struct packed {
      logic       at_center;
      logic       axis;
      logic [1:0] quarter;
      logic       neg_x;
      logic       neg_y;
   } side_type;

   // round(atan(2^-i) * 2^32 / (2*pi))
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

endpackage

`default_nettype wire

/* rtl/pad_prep.sv */
// input stage: offset from center, magnitudes and quadrant classification
`default_nettype none

module pad_prep #(
   parameter int COORD_BITS = pad_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  wire logic [COORD_BITS-1:0] point_x,
   input  wire logic [COORD_BITS-1:0] point_y,
   input  wire logic [COORD_BITS-1:0] center_x,
   input  wire logic [COORD_BITS-1:0] center_y,
   output logic                       dn_valid,
   input  wire logic                  dn_ready,
   output logic [COORD_BITS-1:0]      dn_ax,
   output logic [COORD_BITS-1:0]      dn_ay,
   output pad_pkg::side_type          dn_side
);

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic [COORD_BITS:0]        dx_abs;
   logic [COORD_BITS:0]        dy_abs;
   logic                       valid_ff;
   logic [COORD_BITS-1:0]      ax_ff;
   logic [COORD_BITS-1:0]      ay_ff;
   pad_pkg::side_type          side_ff;
   pad_pkg::side_type          side_in;

   // offset right and offset up (screen y grows downward)
   always_comb begin
      dx     = $signed({1'b0, point_x}) - $signed({1'b0, center_x});
      dy     = $signed({1'b0, center_y}) - $signed({1'b0, point_y});
      dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
      dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
   end

   // classify center, axis and quadrant
   always_comb begin
      side_in.at_center = (dx == '0) && (dy == '0);
      side_in.axis      = (dx == '0) || (dy == '0);
      side_in.neg_x     = dx[COORD_BITS];
      side_in.neg_y     = dy[COORD_BITS];
      if (dy == '0) begin
         side_in.quarter = dx[COORD_BITS] ? 2'd2 : 2'd0;
      end else begin
         side_in.quarter = dy[COORD_BITS] ? 2'd3 : 2'd1;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (up_ready) begin
         ax_ff   <= dx_abs[COORD_BITS-1:0];
         ay_ff   <= dy_abs[COORD_BITS-1:0];
         side_ff <= side_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_ax    = ax_ff;
   assign dn_ay    = ay_ff;
   assign dn_side  = side_ff;

endmodule

`default_nettype wire

/* rtl/pad_cordic.sv */
// unrolled cordic vectoring pipeline, one rotation per register stage
`default_nettype none

module pad_cordic #(
   parameter int COORD_BITS    = pad_pkg::COORD_BITS_DEF,
   parameter int CORDIC_STAGES = pad_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  wire logic [COORD_BITS-1:0] up_ax,
   input  wire logic [COORD_BITS-1:0] up_ay,
   input  wire pad_pkg::side_type     up_side,
   output logic                       dn_valid,
   input  wire logic                  dn_ready,
   output logic signed [pad_pkg::Z_BITS-1:0] dn_z,
   output pad_pkg::side_type          dn_side
);

   localparam int N  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int XW = COORD_BITS + pad_pkg::CORDIC_SCALE + 3;
   localparam int ZW = pad_pkg::Z_BITS;

   logic                 v_ff    [N];
   logic                 rdy     [N+1];
   logic signed [XW-1:0] x_ff    [N-1];
   logic signed [XW-1:0] y_ff    [N-1];
   logic signed [ZW-1:0] z_ff    [N];
   pad_pkg::side_type    side_ff [N];

   assign rdy[N]   = dn_ready;
   assign up_ready = rdy[0];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic signed [XW-1:0] y_src;
      logic signed [ZW-1:0] z_src;
      logic signed [ZW-1:0] z_in;
      logic signed [ZW-1:0] step;
      pad_pkg::side_type    side_src;
      logic                 v_src;

      // source of this stage: input beat or previous stage
      if (k == 0) begin : g_first
         assign y_src    = {3'b000, up_ay, {pad_pkg::CORDIC_SCALE{1'b0}}};
         assign z_src    = '0;
         assign side_src = up_side;
         assign v_src    = up_valid;
      end else begin : g_next
         assign y_src    = y_ff[k-1];
         assign z_src    = z_ff[k-1];
         assign side_src = side_ff[k-1];
         assign v_src    = v_ff[k-1];
      end

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      // angle accumulator, direction set by the sign of y
      assign step = $signed({{(ZW-32){1'b0}}, pad_pkg::ATAN_TAB[k]});
      assign z_in = (y_src > 0) ? (z_src + step) : (z_src - step);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            z_ff[k]    <= z_in;
            side_ff[k] <= side_src;
         end
      end

      // vector rotation, not needed after the last stage
      if (k < N - 1) begin : g_xy
         logic signed [XW-1:0] x_src;
         logic signed [XW-1:0] xs;
         logic signed [XW-1:0] ys;
         logic signed [XW-1:0] x_in;
         logic signed [XW-1:0] y_in;

         // x source: input beat or previous stage
         if (k == 0) begin : g_x_first
            assign x_src = {3'b000, up_ax, {pad_pkg::CORDIC_SCALE{1'b0}}};
         end else begin : g_x_next
            assign x_src = x_ff[k-1];
         end

         always_comb begin
            xs = x_src >>> k;
            ys = y_src >>> k;
            if (y_src > 0) begin
               x_in = x_src + ys;
               y_in = y_src - xs;
            end else begin
               x_in = x_src - ys;
               y_in = y_src + xs;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               x_ff[k] <= x_in;
               y_ff[k] <= y_in;
            end
         end
      end
   end

   assign dn_valid = v_ff[N-1];
   assign dn_z     = z_ff[N-1];
   assign dn_side  = side_ff[N-1];

endmodule

`default_nettype wire

/* rtl/pad_dms.sv */
// quadrant fold, arc-second scaling and degree/minute/second split
`default_nettype none

module pad_dms (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         up_valid,
   output logic                              up_ready,
   input  wire logic signed [pad_pkg::Z_BITS-1:0] up_z,
   input  wire pad_pkg::side_type            up_side,
   output logic                              dn_valid,
   input  wire logic                         dn_ready,
   output logic [8:0]                        dn_degrees,
   output logic [5:0]                        dn_minutes,
   output logic [5:0]                        dn_seconds,
   output logic                              dn_at_center
);

   localparam int S = 8;

   logic [S-1:0] v_ff;
   logic [S-1:0] v_src;
   logic         rdy [S+1];
   logic         f_ff [S];

   logic [30:0]  a_clamp;
   logic [31:0]  ang_in;
   logic [31:0]  ang_ff;
   logic [52:0]  sec_prod;
   logic [20:0]  sec1_ff;
   logic [41:0]  deg_prod;
   logic [20:0]  sec2_ff;
   logic [8:0]   deg2_ff;
   logic [20:0]  deg_mult;
   logic [20:0]  r3_diff;
   logic [12:0]  r3_ff;
   logic [8:0]   deg3_ff;
   logic [8:0]   deg4_ff;
   logic [11:0]  rem4_ff;
   logic [24:0]  min_prod;
   logic [11:0]  rem5_ff;
   logic [5:0]   min5_ff;
   logic [8:0]   deg5_ff;
   logic [11:0]  min_mult;
   logic [11:0]  r6_diff;
   logic [6:0]   r6_ff;
   logic [5:0]   min6_ff;
   logic [8:0]   deg6_ff;
   logic [8:0]   deg7_ff;
   logic [5:0]   min7_ff;
   logic [5:0]   sec7_ff;

   // handshake chain through the stages
   assign rdy[S]   = dn_ready;
   assign up_ready = rdy[0];
   assign v_src    = {v_ff[S-2:0], up_valid};

   for (genvar k = 0; k < S; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < S; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   // center flag travels with the beat
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         f_ff[0] <= up_side.at_center;
      end
      for (int k = 1; k < S; k++) begin
         if (rdy[k]) begin
            f_ff[k] <= f_ff[k-1];
         end
      end
   end

   // clamp the first-quadrant angle and fold it into the full turn
   always_comb begin
      if (up_z < 0) begin
         a_clamp = '0;
      end else if (up_z > $signed({2'b00, pad_pkg::QUARTER_TURN})) begin
         a_clamp = pad_pkg::QUARTER_TURN[30:0];
      end else begin
         a_clamp = up_z[30:0];
      end
      if (up_side.at_center) begin
         ang_in = '0;
      end else if (up_side.axis) begin
         ang_in = {up_side.quarter, 30'd0};
      end else if (!up_side.neg_x && !up_side.neg_y) begin
         ang_in = {1'b0, a_clamp};
      end else if (up_side.neg_x && !up_side.neg_y) begin
         ang_in = pad_pkg::HALF_TURN - {1'b0, a_clamp};
      end else if (up_side.neg_x && up_side.neg_y) begin
         ang_in = pad_pkg::HALF_TURN + {1'b0, a_clamp};
      end else begin
         ang_in = 32'd0 - {1'b0, a_clamp};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ang_ff <= ang_in;
      end
   end

   // arc-seconds = floor(angle * 1296000 / 2^32)
   assign sec_prod = {21'd0, ang_ff} * 53'(pad_pkg::ARCSEC_PER_TURN);

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         sec1_ff <= sec_prod[52:32];
      end
   end

   // degree estimate by reciprocal, low by at most one
   assign deg_prod = {21'd0, sec1_ff} * 42'(pad_pkg::DEG_RECIP);

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         sec2_ff <= sec1_ff;
         deg2_ff <= deg_prod[pad_pkg::DEG_RECIP_SHIFT+8:pad_pkg::DEG_RECIP_SHIFT];
      end
   end

   // remainder after the degree estimate, below two degrees
   assign deg_mult = 21'(deg2_ff) * 21'(pad_pkg::SEC_PER_DEG);
   assign r3_diff  = sec2_ff - deg_mult;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         r3_ff   <= r3_diff[12:0];
         deg3_ff <= deg2_ff;
      end
   end

   // degree correction
   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         if (r3_ff >= 13'(pad_pkg::SEC_PER_DEG)) begin
            deg4_ff <= deg3_ff + 9'd1;
            rem4_ff <= 12'(r3_ff - 13'(pad_pkg::SEC_PER_DEG));
         end else begin
            deg4_ff <= deg3_ff;
            rem4_ff <= r3_ff[11:0];
         end
      end
   end

   // minute estimate by reciprocal
   assign min_prod = {13'd0, rem4_ff} * 25'(pad_pkg::MIN_RECIP);

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         rem5_ff <= rem4_ff;
         min5_ff <= min_prod[pad_pkg::MIN_RECIP_SHIFT+5:pad_pkg::MIN_RECIP_SHIFT];
         deg5_ff <= deg4_ff;
      end
   end

   // remainder after the minute estimate, below two minutes
   assign min_mult = 12'(min5_ff) * 12'(pad_pkg::SEC_PER_MIN);
   assign r6_diff  = rem5_ff - min_mult;

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         r6_ff   <= r6_diff[6:0];
         min6_ff <= min5_ff;
         deg6_ff <= deg5_ff;
      end
   end

   // minute correction into the output register
   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         deg7_ff <= deg6_ff;
         if (r6_ff >= 7'(pad_pkg::SEC_PER_MIN)) begin
            min7_ff <= min6_ff + 6'd1;
            sec7_ff <= 6'(r6_ff - 7'(pad_pkg::SEC_PER_MIN));
         end else begin
            min7_ff <= min6_ff;
            sec7_ff <= r6_ff[5:0];
         end
      end
   end

   assign dn_valid     = v_ff[S-1];
   assign dn_degrees   = deg7_ff;
   assign dn_minutes   = min7_ff;
   assign dn_seconds   = sec7_ff;
   assign dn_at_center = f_ff[S-1];

   // results stay in range
   a_range : assert property (@(posedge clock) disable iff (reset)
      v_ff[S-1] |-> (deg7_ff < 9'd360) && (min7_ff < 6'd60) && (sec7_ff < 6'd60))
      else $error("dms output out of range");

   // remainder estimates never miss by more than one unit
   a_rem : assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] |-> rem4_ff < 12'(pad_pkg::SEC_PER_DEG)) and
      (v_ff[6] |-> r6_ff < 7'(2 * pad_pkg::SEC_PER_MIN)))
      else $error("reciprocal estimate off by more than one");

   // center point always reads as zero angle
   a_center : assert property (@(posedge clock) disable iff (reset)
      (v_ff[S-1] && f_ff[S-1]) |-> (deg7_ff == '0) && (min7_ff == '0) && (sec7_ff == '0))
      else $error("center point gives a nonzero angle");

endmodule

`default_nettype wire

/* rtl/point_azimuth_to_dms_top.sv */
// top level of the point azimuth to degrees/minutes/seconds pipeline
`default_nettype none

// Gives the azimuth of a screen point around a programmable center as whole
// degrees, arc-minutes and arc-seconds, counterclockwise from +x with y down.
// Request channel: req_valid with req_point_x/req_point_y; a beat is taken
// at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid with the angle fields and rsp_at_center; a beat
// is taken at an edge with rsp_valid high and rsp_stall low.
// Config channel: csr_valid/csr_ready with csr_index (0 center x, 1 center y)
// and csr_wdata; csr_ready is always high. Write only while the pipe is empty.
// Stages: one input stage, min(CORDIC_STAGES, 32) cordic stages (24 by default)
// with one rotation per stage, and eight stages of quadrant fold, arc-second
// scaling and constant division.
// Throughput: one point per cycle while the response is not stalled; every
// stage is a register with its own valid bit.
// Stall: a stalled response holds; upstream stages keep filling bubbles, and
// req_stall rises only when every stage holds a beat.
// Reset: all valid bits clear, both center registers go to 300.

module point_azimuth_to_dms_top #(
   parameter int COORD_BITS    = pad_pkg::COORD_BITS_DEF,
   parameter int CORDIC_STAGES = pad_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_BITS-1:0] req_point_x,
   input  wire logic [COORD_BITS-1:0] req_point_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [8:0]                 rsp_degrees,
   output logic [5:0]                 rsp_minutes,
   output logic [5:0]                 rsp_seconds,
   output logic                       rsp_at_center,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [0:0]            csr_index,
   input  wire logic [COORD_BITS-1:0] csr_wdata
);

   logic [COORD_BITS-1:0] center_x_ff;
   logic [COORD_BITS-1:0] center_y_ff;
   logic                  prep_ready;
   logic                  prep_valid;
   logic [COORD_BITS-1:0] prep_ax;
   logic [COORD_BITS-1:0] prep_ay;
   pad_pkg::side_type     prep_side;
   logic                  cordic_ready;
   logic                  cordic_valid;
   logic signed [pad_pkg::Z_BITS-1:0] cordic_z;
   pad_pkg::side_type     cordic_side;
   logic                  dms_ready;

   // center registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= COORD_BITS'(pad_pkg::CENTER_RESET);
         center_y_ff <= COORD_BITS'(pad_pkg::CENTER_RESET);
      end else if (csr_valid && csr_ready) begin
         case (pad_pkg::csr_index_type'(csr_index))
            pad_pkg::CSR_CENTER_X: center_x_ff <= csr_wdata;
            pad_pkg::CSR_CENTER_Y: center_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = !prep_ready;

   // offset and quadrant
   pad_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (prep_ready),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .dn_valid (prep_valid),
      .dn_ready (cordic_ready),
      .dn_ax    (prep_ax),
      .dn_ay    (prep_ay),
      .dn_side  (prep_side)
   );

   // first-quadrant arctangent
   pad_cordic #(
      .COORD_BITS    (COORD_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prep_valid),
      .up_ready (cordic_ready),
      .up_ax    (prep_ax),
      .up_ay    (prep_ay),
      .up_side  (prep_side),
      .dn_valid (cordic_valid),
      .dn_ready (dms_ready),
      .dn_z     (cordic_z),
      .dn_side  (cordic_side)
   );

   // full-turn angle to degrees, minutes, seconds
   pad_dms u_dms (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (cordic_valid),
      .up_ready     (dms_ready),
      .up_z         (cordic_z),
      .up_side      (cordic_side),
      .dn_valid     (rsp_valid),
      .dn_ready     (!rsp_stall),
      .dn_degrees   (rsp_degrees),
      .dn_minutes   (rsp_minutes),
      .dn_seconds   (rsp_seconds),
      .dn_at_center (rsp_at_center)
   );

   // nothing comes out in the cycle right after reset
   a_reset_empty : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
